### hw/rtl/sktu_pkg.sv
// Package for the sorted key table unit: request and status codes,
// sequencer states, result record and configuration register map.
// Depends on nothing; used by every module of the unit but sktu_ram.
`default_nettype none

package sktu_pkg;

  localparam int unsigned KEY_W   = 32;
  localparam int unsigned OP_W    = 2;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned POS_W   = 6;
  localparam int unsigned TOTAL_W = 7;
  localparam int unsigned LIMIT_W = 7;

  localparam logic [OP_W-1:0] OP_FIND   = 2'd0;
  localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

  localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL      = 2'd2;

  // APB map: one 32-bit register at byte address 0
  localparam int unsigned      CFG_ADDR_W      = 3;
  localparam int unsigned      CFG_DATA_W      = 32;
  localparam logic             REG_CAP_LIMIT   = 1'b0;
  localparam logic [LIMIT_W-1:0] CAP_LIMIT_RESET = 7'd64;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PROBE,
    ST_CMP,
    ST_DECIDE,
    ST_SHIFT,
    ST_PLACE,
    ST_RD_MIN,
    ST_RD_MAX,
    ST_RD_LAST,
    ST_DONE
  } sktu_state_e;

  typedef struct packed {
    logic [STAT_W-1:0]       status;
    logic [POS_W-1:0]        position;
    logic [TOTAL_W-1:0]      entry_total;
    logic signed [KEY_W-1:0] smallest_key;
    logic signed [KEY_W-1:0] largest_key;
  } sktu_result_t;

endpackage

`default_nettype wire

### hw/rtl/sorted_key_table_unit.sv
// Sorted key table: a request runs a binary search of at most ceil(log2(n+1)) steps over the n
// keys held, then for an insert or a found remove a shift walk that moves the keys behind its
// place, then a readback of the smallest and largest key, skipped when the table is left empty.
// One request at a time: the next is taken in the cycle after the result leaves the sequencer.
// Reset (asynchronous, active low) empties the table and sets the limit to 64; no RAM clear.
`default_nettype none

module sorted_key_table_unit #(
  parameter int unsigned CAPACITY = 64
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // request channel
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire logic [sktu_pkg::OP_W-1:0]          op_i,
  input  wire logic signed [sktu_pkg::KEY_W-1:0]  key_i,
  // result channel
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output logic      [sktu_pkg::STAT_W-1:0]        status_o,
  output logic      [sktu_pkg::POS_W-1:0]         position_o,
  output logic      [sktu_pkg::TOTAL_W-1:0]       entry_total_o,
  output logic signed [sktu_pkg::KEY_W-1:0]       smallest_key_o,
  output logic signed [sktu_pkg::KEY_W-1:0]       largest_key_o,
  // configuration port
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [sktu_pkg::CFG_ADDR_W-1:0]    paddr,
  input  wire logic [sktu_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic      [sktu_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                                    pready
);
  import sktu_pkg::*;

  localparam int unsigned IDX_W = $clog2(CAPACITY);

  logic [LIMIT_W-1:0] cap_limit;
  logic               req_ready;
  logic               res_valid, res_ready, res_load;
  sktu_result_t       res;
  sktu_result_t       out_q;
  logic               out_valid_q, out_valid_d;

  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr, ram_raddr;
  logic [KEY_W-1:0]   ram_wdata, ram_rdata;

  // capacity limit register behind the APB port
  sktu_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .cap_limit_o (cap_limit)
  );

  // key store: one entry per slot, kept in ascending signed order
  sktu_ram #(
    .WIDTH (KEY_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // search, shift and min/max readback sequencer
  sktu_seq #(
    .CAPACITY (CAPACITY)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (in_valid_i),
    .req_ready_o (req_ready),
    .req_op_i    (op_i),
    .req_key_i   (key_i),
    .cap_limit_i (cap_limit),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  assign in_stall_o = !req_ready;

  // Output register: take a finished result whenever the slot is empty or
  // drains this cycle, so the sequencer can start the next request at once.
  assign res_ready = !out_valid_q || !out_stall_i;
  assign res_load  = res_valid && res_ready;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // hold the payload while stalled
  always_ff @(posedge clk_i) begin
    if (res_load) begin
      out_q <= res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_q.status;
  assign position_o     = out_q.position;
  assign entry_total_o  = out_q.entry_total;
  assign smallest_key_o = out_q.smallest_key;
  assign largest_key_o  = out_q.largest_key;

endmodule

`default_nettype wire

### hw/rtl/sktu_ram.sv
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
`default_nettype none

module sktu_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

### hw/rtl/sktu_cfg.sv
// APB configuration register block: holds the capacity limit.
// Depends on sktu_pkg for the register map and reset value.
`default_nettype none

module sktu_cfg (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [sktu_pkg::CFG_ADDR_W-1:0]    paddr,
  input  wire logic [sktu_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic      [sktu_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                                    pready,
  output logic      [sktu_pkg::LIMIT_W-1:0]       cap_limit_o
);
  import sktu_pkg::*;

  logic               reg_hit;
  logic [LIMIT_W-1:0] cap_limit_q, cap_limit_d;

  assign reg_hit = (paddr[CFG_ADDR_W-1:2] == REG_CAP_LIMIT);
  assign pready  = 1'b1;

  always_comb begin
    cap_limit_d = cap_limit_q;
    if (psel && penable && pwrite && reg_hit) begin
      cap_limit_d = pwdata[LIMIT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_limit_q <= CAP_LIMIT_RESET;
    end else begin
      cap_limit_q <= cap_limit_d;
    end
  end

  assign prdata      = reg_hit ? CFG_DATA_W'(cap_limit_q) : '0;
  assign cap_limit_o = cap_limit_q;

endmodule

`default_nettype wire

### hw/rtl/sktu_seq.sv
// Request sequencer: binary search, shift walk and min/max readback over
// the key RAM. Depends on sktu_pkg; drives the ports of one sktu_ram.
`default_nettype none

module sktu_seq #(
  parameter int unsigned CAPACITY = 64
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                req_valid_i,
  output logic                                     req_ready_o,
  input  wire logic [sktu_pkg::OP_W-1:0]           req_op_i,
  input  wire logic signed [sktu_pkg::KEY_W-1:0]   req_key_i,
  input  wire logic [sktu_pkg::LIMIT_W-1:0]        cap_limit_i,
  output logic                                     res_valid_o,
  input  wire logic                                res_ready_i,
  output sktu_pkg::sktu_result_t                   res_o,
  output logic                                     ram_we_o,
  output logic [$clog2(CAPACITY)-1:0]              ram_waddr_o,
  output logic [sktu_pkg::KEY_W-1:0]               ram_wdata_o,
  output logic [$clog2(CAPACITY)-1:0]              ram_raddr_o,
  input  wire logic [sktu_pkg::KEY_W-1:0]          ram_rdata_i
);
  import sktu_pkg::*;

  localparam int unsigned IDX_W = $clog2(CAPACITY);
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned LIM_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

  sktu_state_e state_q, state_d;

  logic [OP_W-1:0]         op_q, op_d;
  logic signed [KEY_W-1:0] key_q, key_d;
  logic [CNT_W-1:0]        lo_q, lo_d, hi_q, hi_d, mid_q, mid_d;
  logic                    eq_q, eq_d;
  logic [CNT_W-1:0]        count_q, count_d;
  logic [CNT_W-1:0]        rem_q, rem_d;
  logic [IDX_W-1:0]        rd_ptr_q, rd_ptr_d, rd_addr_q, rd_addr_d;
  logic                    rd_act_q, rd_act_d;
  logic [IDX_W-1:0]        pos_q, pos_d;
  logic [STAT_W-1:0]       status_q, status_d;
  logic signed [KEY_W-1:0] min_q, min_d, max_q, max_d;

  logic                    is_ins, is_rem, full, found, go_right;
  logic [CNT_W:0]          mid_sum;
  logic [CNT_W-1:0]        mid;
  logic [CNT_W-1:0]        ins_rem, del_rem;
  logic signed [KEY_W-1:0] rd_key;

  assign is_ins   = (op_q == OP_INSERT);
  assign is_rem   = (op_q == OP_REMOVE);
  assign full     = (LIM_W'(count_q) >= LIM_W'(cap_limit_i)) ||
                    (count_q >= CNT_W'(CAPACITY));
  assign found    = eq_q;
  assign mid_sum  = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid      = mid_sum[CNT_W:1];
  assign rd_key   = ram_rdata_i;
  assign go_right = is_ins ? (rd_key <= key_q) : (rd_key < key_q);
  assign ins_rem  = count_q - lo_q;
  assign del_rem  = count_q - lo_q - CNT_W'(1);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:    if (req_valid_i) state_d = ST_PROBE;
      ST_PROBE:   state_d = (lo_q < hi_q) ? ST_CMP : ST_DECIDE;
      ST_CMP:     state_d = ST_PROBE;
      ST_DECIDE: begin
        if (is_ins) begin
          if (full)                 state_d = ST_RD_MIN;
          else if (ins_rem != '0)   state_d = ST_SHIFT;
          else                      state_d = ST_PLACE;
        end else if (is_rem && found && (del_rem != '0)) begin
          state_d = ST_SHIFT;
        end else begin
          state_d = ST_RD_MIN;
        end
      end
      ST_SHIFT:   if (rem_q == '0) state_d = is_ins ? ST_PLACE : ST_RD_MIN;
      ST_PLACE:   state_d = ST_RD_MIN;
      ST_RD_MIN:  state_d = (count_q == '0) ? ST_DONE : ST_RD_MAX;
      ST_RD_MAX:  state_d = ST_RD_LAST;
      ST_RD_LAST: state_d = ST_DONE;
      ST_DONE:    if (res_ready_i) state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  // datapath and RAM control
  always_comb begin
    op_d      = op_q;
    key_d     = key_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    mid_d     = mid_q;
    eq_d      = eq_q;
    count_d   = count_q;
    rem_d     = rem_q;
    rd_ptr_d  = rd_ptr_q;
    rd_addr_d = rd_addr_q;
    rd_act_d  = rd_act_q;
    pos_d     = pos_q;
    status_d  = status_q;
    min_d     = min_q;
    max_d     = max_q;

    ram_we_o    = 1'b0;
    ram_waddr_o = is_ins ? (rd_addr_q + IDX_W'(1)) : (rd_addr_q - IDX_W'(1));
    ram_wdata_o = ram_rdata_i;
    ram_raddr_o = rd_ptr_q;

    case (state_q)
      ST_IDLE: begin
        if (req_valid_i) begin
          op_d     = req_op_i;
          key_d    = req_key_i;
          lo_d     = '0;
          hi_d     = count_q;
          eq_d     = 1'b0;
          pos_d    = '0;
          status_d = STAT_OK;
        end
      end
      ST_PROBE: begin
        ram_raddr_o = mid[IDX_W-1:0];
        mid_d       = mid;
      end
      ST_CMP: begin
        if (go_right) begin
          lo_d = mid_q + CNT_W'(1);
        end else begin
          hi_d = mid_q;
          eq_d = (rd_key == key_q);
        end
      end
      ST_DECIDE: begin
        rd_act_d = 1'b0;
        if (is_ins) begin
          if (full) begin
            status_d = STAT_FULL;
          end else begin
            pos_d    = lo_q[IDX_W-1:0];
            count_d  = count_q + CNT_W'(1);
            rem_d    = ins_rem;
            rd_ptr_d = IDX_W'(count_q - CNT_W'(1));
          end
        end else if (found) begin
          pos_d = lo_q[IDX_W-1:0];
          if (is_rem) begin
            count_d  = count_q - CNT_W'(1);
            rem_d    = del_rem;
            rd_ptr_d = IDX_W'(lo_q + CNT_W'(1));
          end
        end else begin
          status_d = STAT_NOT_FOUND;
        end
      end
      ST_SHIFT: begin
        // write back the entry read last cycle one place over
        ram_we_o = rd_act_q;
        if (rem_q != '0) begin
          ram_raddr_o = rd_ptr_q;
          rd_addr_d   = rd_ptr_q;
          rd_act_d    = 1'b1;
          rd_ptr_d    = is_ins ? (rd_ptr_q - IDX_W'(1)) : (rd_ptr_q + IDX_W'(1));
          rem_d       = rem_q - CNT_W'(1);
        end else begin
          rd_act_d = 1'b0;
        end
      end
      ST_PLACE: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = pos_q;
        ram_wdata_o = key_q;
      end
      ST_RD_MIN: begin
        ram_raddr_o = '0;
        if (count_q == '0) begin
          min_d = '0;
          max_d = '0;
        end
      end
      ST_RD_MAX: begin
        min_d       = rd_key;
        ram_raddr_o = IDX_W'(count_q - CNT_W'(1));
      end
      ST_RD_LAST: begin
        max_d = rd_key;
      end
      ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      count_q  <= '0;
      rd_act_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      rd_act_q <= rd_act_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    key_q     <= key_d;
    lo_q      <= lo_d;
    hi_q      <= hi_d;
    mid_q     <= mid_d;
    eq_q      <= eq_d;
    rem_q     <= rem_d;
    rd_ptr_q  <= rd_ptr_d;
    rd_addr_q <= rd_addr_d;
    pos_q     <= pos_d;
    status_q  <= status_d;
    min_q     <= min_d;
    max_q     <= max_d;
  end

  assign req_ready_o       = (state_q == ST_IDLE);
  assign res_valid_o       = (state_q == ST_DONE);
  assign res_o.status      = status_q;
  assign res_o.position    = POS_W'(pos_q);
  assign res_o.entry_total = TOTAL_W'(count_q);
  assign res_o.smallest_key = min_q;
  assign res_o.largest_key  = max_q;

endmodule

`default_nettype wire
